@@ rtl/lbcp_pkg.sv @@
// Shared types and constants of the leaky bucket cell policer.
package lbcp_pkg;

  localparam int SLOT_W     = 32;
  localparam int CHAN_W     = 16;
  localparam int LEVEL_W    = 10;
  localparam int IDX_W      = 10;
  localparam int STAT_W     = 32;
  localparam int DISC_W     = 32;
  localparam int PROD_W     = SLOT_W + LEVEL_W;
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Item kinds on the input tuser.
  localparam logic [1:0] KIND_ARRIVAL    = 2'd0;
  localparam logic [1:0] KIND_TB_RESET   = 2'd1;
  localparam logic [1:0] KIND_HIST_READ  = 2'd2;
  localparam logic [1:0] KIND_HIST_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_INCREMENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_PER_SLOT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SIZE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICE_ALL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICED_CHANNEL  = 3'd4;

  localparam logic [LEVEL_W-1:0] RST_BUCKET_INCREMENT = 10'd10;
  localparam logic [LEVEL_W-1:0] RST_LEAK_PER_SLOT    = 10'd5;
  localparam logic [LEVEL_W-1:0] RST_BUCKET_SIZE      = 10'd20;
  localparam logic               RST_POLICE_ALL       = 1'b1;
  localparam logic [CHAN_W-1:0]  RST_POLICED_CHANNEL  = 16'd0;

  typedef enum logic [2:0] {
    OP_CELL,
    OP_PASS,
    OP_TB_RESET,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] bucket_increment;
    logic [LEVEL_W-1:0] leak_per_slot;
    logic [LEVEL_W-1:0] bucket_size;
    logic               police_all;
    logic [CHAN_W-1:0]  policed_channel;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] now_slot;
    logic [IDX_W-1:0]  stat_index;
  } cmd_t;

  typedef struct packed {
    logic               pass_cell;
    logic [LEVEL_W-1:0] level_after;
    logic [STAT_W-1:0]  stat_value;
    logic [DISC_W-1:0]  discards;
    logic               discard_wrapped;
  } result_t;

endpackage

@@ rtl/leaky_bucket_cell_policer.sv @@
// Top level of the leaky bucket cell policer: config registers, front, queue, back.
//
// Input stream (s_*): one request per item; tuser holds the item kind (arrival,
// time base reset, histogram read, histogram clear), tdata the slot, channel and
// histogram index. Output stream (m_*): exactly one result per request, in order.
// Config port: cfg_we writes cfg_data into register cfg_index; write
// only while no request is in flight.
// Result path: an unpoliced arrival is answered straight from idle, a histogram read
// after a store read, a time base reset or discarded cell after the drain multiply
// and decision, a conforming cell after those and then a histogram read-modify-write
// on the histogram store. A histogram clear walks the whole store before its result.
// The back end handles one request at a time; it takes the next from the queue
// only once the result of the last is registered.
// Reset: config returns to defaults, bucket, time base and discard count clear,
// and the histogram is zeroed by a pass over the whole store during which
// s_tready stays low.
// Receiver stall: the result register holds; the two-entry queue keeps accepting
// requests until it fills, then s_tready drops.
module leaky_bucket_cell_policer #(
  parameter int HIST_DEPTH  = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic [lbcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // now_slot[31:0], cell_channel[47:32], stat_index[57:48], zero pad
  input  logic [lbcp_pkg::IN_TDATA_W-1:0]    s_tdata,
  // kind[1:0]
  input  logic [1:0]                         s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pass_cell[0], level_after[10:1], stat_value[42:11], discards[74:43],
  // discard_wrapped[75], zero pad
  output logic [lbcp_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import lbcp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  cmd_t    q_head;
  result_t res;
  logic    push;
  logic    q_ready;
  logic    q_valid;
  logic    q_pop;
  logic    hold;

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bucket_increment <= RST_BUCKET_INCREMENT;
      cfg.leak_per_slot    <= RST_LEAK_PER_SLOT;
      cfg.bucket_size      <= RST_BUCKET_SIZE;
      cfg.police_all       <= RST_POLICE_ALL;
      cfg.policed_channel  <= RST_POLICED_CHANNEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUCKET_INCREMENT: cfg.bucket_increment <= cfg_data[LEVEL_W-1:0];
        CFG_LEAK_PER_SLOT:    cfg.leak_per_slot    <= cfg_data[LEVEL_W-1:0];
        CFG_BUCKET_SIZE:      cfg.bucket_size      <= cfg_data[LEVEL_W-1:0];
        CFG_POLICE_ALL:       cfg.police_all       <= cfg_data[0];
        CFG_POLICED_CHANNEL:  cfg.policed_channel  <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify each request into a command.
  lbcp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_ready  (q_ready),
    .hold     (hold),
    .push     (push),
    .cmd      (cmd)
  );

  // Decouples acceptance from execution.
  lbcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  // Bucket state, histogram and result register.
  lbcp_back #(
    .HIST_DEPTH  (HIST_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .hold     (hold),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {4'b0, res.discard_wrapped, res.discards, res.stat_value,
                    res.level_after, res.pass_cell};

endmodule

@@ rtl/lbcp_front.sv @@
// Front end: accepts input requests and classifies them into back-end commands.
module lbcp_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lbcp_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]                       s_tuser,
  input  lbcp_pkg::cfg_t                   cfg,
  input  logic                             q_ready,
  input  logic                             hold,
  output logic                             push,
  output lbcp_pkg::cmd_t                   cmd
);
  import lbcp_pkg::*;

  logic [SLOT_W-1:0] now_slot;
  logic [CHAN_W-1:0] cell_channel;
  logic [IDX_W-1:0]  stat_index;
  logic              policed;

  assign now_slot     = s_tdata[SLOT_W-1:0];
  assign cell_channel = s_tdata[SLOT_W+CHAN_W-1:SLOT_W];
  assign stat_index   = s_tdata[SLOT_W+CHAN_W+IDX_W-1:SLOT_W+CHAN_W];

  assign policed  = cfg.police_all || (cell_channel == cfg.policed_channel);
  assign s_tready = q_ready && !hold;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.now_slot   = now_slot;
    cmd.stat_index = stat_index;
    unique case (s_tuser)
      KIND_ARRIVAL:    cmd.op = policed ? OP_CELL : OP_PASS;
      KIND_TB_RESET:   cmd.op = OP_TB_RESET;
      KIND_HIST_READ:  cmd.op = OP_READ;
      KIND_HIST_CLEAR: cmd.op = OP_CLEAR;
      default:         cmd.op = OP_CLEAR;
    endcase
  end

endmodule

@@ rtl/lbcp_queue.sv @@
// Short command queue between front and back end.
module lbcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lbcp_pkg::cmd_t push_data,
  output logic           ready,
  output logic           valid,
  output lbcp_pkg::cmd_t head,
  input  logic           pop
);
  import lbcp_pkg::*;

  cmd_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign ready = (count != Q_CW'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lbcp_back.sv @@
// Back end: bucket arithmetic, histogram memory and the result register.
module lbcp_back #(
  parameter int HIST_DEPTH  = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  lbcp_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  lbcp_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              hold,
  output logic              m_tvalid,
  input  logic              m_tready,
  output lbcp_pkg::result_t res
);
  import lbcp_pkg::*;

  localparam int AW = $clog2(HIST_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DECIDE,
    S_BUMP,
    S_READ
  } state_t;

  state_t             state;
  op_t                op_q;
  logic [LEVEL_W-1:0] level;
  logic [SLOT_W-1:0]  last_slot;
  logic [DISC_W-1:0]  disc;
  logic [SLOT_W-1:0]  elapsed;
  logic [PROD_W-1:0]  product;
  logic [AW-1:0]      clr_addr;
  logic               clr_emit;
  logic [AW-1:0]      bump_addr;
  logic               bump_en;
  logic               stat_ok;

  logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;

  logic               out_free;
  logic [LEVEL_W-1:0] drained;
  logic [LEVEL_W:0]   sum;
  logic               discard;
  logic [31:0]        drained_ext;
  logic               drained_ok;
  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [DISC_W-1:0]  disc_inc;
  logic [63:0]        rdata_ext;

  assign out_free    = !m_tvalid || m_tready;
  assign drained     = (product >= PROD_W'(level)) ? '0 : level - product[LEVEL_W-1:0];
  assign sum         = {1'b0, drained} + {1'b0, cfg.bucket_increment};
  assign discard     = sum > {1'b0, cfg.bucket_size};
  assign drained_ext = 32'(drained);
  assign drained_ok  = drained_ext < 32'(HIST_DEPTH);
  assign idx_ext     = 32'(q_head.stat_index);
  assign idx_ok      = idx_ext < 32'(HIST_DEPTH);
  assign disc_inc    = disc + 1'b1;
  assign rdata_ext   = 64'(rdata);
  assign hold        = (state == S_CLEAR) && !clr_emit;

  assign q_pop = (state == S_IDLE) && q_valid && ((q_head.op != OP_PASS) || out_free);

  // Histogram store, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = drained_ext[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re    = q_valid && (q_head.op == OP_READ);
        mem_raddr = idx_ext[AW-1:0];
      end
      S_DECIDE: begin
        mem_re = (op_q == OP_CELL) && !discard;
      end
      S_BUMP: begin
        mem_we    = out_free && bump_en;
        mem_waddr = bump_addr;
        mem_wdata = rdata + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_emit  <= 1'b0;
      level     <= '0;
      last_slot <= '0;
      disc      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(HIST_DEPTH - 1)) begin
            if (!clr_emit) begin
              clr_addr <= '0;
              state    <= S_IDLE;
            end else if (out_free) begin
              m_tvalid <= 1'b1;
              res      <= '{1'b0, level, '0, disc, 1'b0};
              clr_emit <= 1'b0;
              clr_addr <= '0;
              state    <= S_IDLE;
            end
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_head.op)
              OP_PASS: begin
                if (out_free) begin
                  m_tvalid <= 1'b1;
                  res      <= '{1'b1, level, '0, disc, 1'b0};
                end
              end
              OP_CELL, OP_TB_RESET: begin
                elapsed   <= (q_head.now_slot >= last_slot) ? q_head.now_slot - last_slot : '0;
                last_slot <= (q_head.op == OP_CELL) ? q_head.now_slot : '0;
                op_q      <= q_head.op;
                state     <= S_MUL;
              end
              OP_READ: begin
                stat_ok <= idx_ok;
                state   <= S_READ;
              end
              OP_CLEAR: begin
                clr_emit <= 1'b1;
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          product <= PROD_W'(elapsed) * PROD_W'(cfg.leak_per_slot);
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (op_q != OP_CELL) begin
            if (out_free) begin
              level    <= drained;
              m_tvalid <= 1'b1;
              res      <= '{1'b0, drained, '0, disc, 1'b0};
              state    <= S_IDLE;
            end
          end else if (discard) begin
            if (out_free) begin
              level    <= drained;
              disc     <= disc_inc;
              m_tvalid <= 1'b1;
              res      <= '{1'b0, drained, '0, disc_inc, (disc_inc == '0)};
              state    <= S_IDLE;
            end
          end else begin
            level     <= sum[LEVEL_W-1:0];
            bump_addr <= drained_ext[AW-1:0];
            bump_en   <= drained_ok;
            state     <= S_BUMP;
          end
        end
        S_BUMP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            res      <= '{1'b1, level, '0, disc, 1'b0};
            state    <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            res      <= '{1'b0, level, (stat_ok ? rdata_ext[STAT_W-1:0] : '0), disc, 1'b0};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sim/tb_leaky_bucket_cell_policer.sv @@
// Self-checking testbench for the leaky bucket cell policer: directed and random requests.
module tb_leaky_bucket_cell_policer;
  timeunit 1ns;
  timeprecision 1ps;

  import lbcp_pkg::*;

  localparam int HIST_ENTRIES = 1024;
  localparam int REQS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 8;      // slowest non-clear request is a conforming cell
  localparam int MAX_PRINTED = 200;

  // Tracks the bucket, time base, histogram and discard count alongside the DUT.
  // note_request works out the result of each accepted request and queues it;
  // check_result compares each delivered result with the oldest queued one.
  class policer_scoreboard;
    cfg_t             regs;
    logic [9:0]       level;
    logic [31:0]      last_slot;
    logic [31:0]      occupancy [HIST_ENTRIES];
    logic [31:0]      discard_count;
    result_t          due_results [$];
    int               errors;
    int               checked;
    int               kind_count [4];

    function new();
      regs.bucket_increment = RST_BUCKET_INCREMENT;
      regs.leak_per_slot    = RST_LEAK_PER_SLOT;
      regs.bucket_size      = RST_BUCKET_SIZE;
      regs.police_all       = RST_POLICE_ALL;
      regs.policed_channel  = RST_POLICED_CHANNEL;
      level = '0;
      last_slot = '0;
      discard_count = '0;
      foreach (occupancy[i]) occupancy[i] = '0;
      errors = 0;
      checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BUCKET_INCREMENT: regs.bucket_increment = val[9:0];
        CFG_LEAK_PER_SLOT:    regs.leak_per_slot    = val[9:0];
        CFG_BUCKET_SIZE:      regs.bucket_size      = val[9:0];
        CFG_POLICE_ALL:       regs.police_all       = val[0];
        CFG_POLICED_CHANNEL:  regs.policed_channel  = val;
        default: ;
      endcase
    endfunction

    // Leak since the last policed arrival or time base reset; time running backwards leaks nothing.
    function void drain_to(logic [31:0] now);
      logic [31:0] elapsed;
      logic [41:0] amount;
      elapsed = (now >= last_slot) ? now - last_slot : 32'd0;
      amount = {10'd0, elapsed} * {32'd0, regs.leak_per_slot};
      if (amount >= {32'd0, level}) level = '0;
      else level = level - amount[9:0];
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] now, logic [15:0] chan,
                               logic [9:0] idx);
      result_t r;
      r = '0;
      kind_count[kind]++;
      case (kind)
        KIND_ARRIVAL: begin
          if (!regs.police_all && chan != regs.policed_channel) begin
            r.pass_cell = 1'b1;
          end else begin
            drain_to(now);
            last_slot = now;
            if ({1'b0, level} + {1'b0, regs.bucket_increment} > {1'b0, regs.bucket_size}) begin
              discard_count = discard_count + 32'd1;
              if (discard_count == '0) r.discard_wrapped = 1'b1;
            end else begin
              occupancy[level] = occupancy[level] + 32'd1;
              level = level + regs.bucket_increment;
              r.pass_cell = 1'b1;
            end
          end
        end
        KIND_TB_RESET: begin
          drain_to(now);
          last_slot = '0;
        end
        KIND_HIST_READ: r.stat_value = occupancy[idx];
        default: foreach (occupancy[i]) occupancy[i] = '0;
      endcase
      r.level_after = level;
      r.discards = discard_count;
      due_results.push_back(r);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding (%h)", got));
      end else begin
        want = due_results.pop_front();
        checked++;
        if (got.pass_cell !== want.pass_cell)
          report_mismatch($sformatf("result %0d pass_cell %b, want %b",
                                    checked, got.pass_cell, want.pass_cell));
        if (got.level_after !== want.level_after)
          report_mismatch($sformatf("result %0d level_after %0d, want %0d",
                                    checked, got.level_after, want.level_after));
        if (got.stat_value !== want.stat_value)
          report_mismatch($sformatf("result %0d stat_value %0d, want %0d",
                                    checked, got.stat_value, want.stat_value));
        if (got.discards !== want.discards)
          report_mismatch($sformatf("result %0d discards %0d, want %0d",
                                    checked, got.discards, want.discards));
        if (got.discard_wrapped !== want.discard_wrapped)
          report_mismatch($sformatf("result %0d discard_wrapped %b, want %b",
                                    checked, got.discard_wrapped, want.discard_wrapped));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // now_slot[31:0], cell_channel[47:32], stat_index[57:48], zero pad
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // kind[1:0]
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // pass_cell[0], level_after[10:1], stat_value[42:11], discards[74:43],
  // discard_wrapped[75], zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;

  policer_scoreboard sb;
  int          tx_idle_pct = 0;   // chance of a gap before each request
  int          rx_idle_pct = 0;   // chance of m_tready low in a cycle
  logic [31:0] cur_slot = '0;     // running time base for random arrivals
  int          settings_used = 0;

  always #4 clk = ~clk;

  leaky_bucket_cell_policer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic result_t unpack_result(logic [OUT_TDATA_W-1:0] d);
    result_t r;
    r.pass_cell       = d[0];
    r.level_after     = d[10:1];
    r.stat_value      = d[42:11];
    r.discards        = d[74:43];
    r.discard_wrapped = d[75];
    return r;
  endfunction

  // Result side: values sampled at the edge are those from before it, so the
  // handshake seen here is the one that completes at this edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(unpack_result(m_tdata));
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // One request. s_tvalid stays high after acceptance so back-to-back requests
  // never lower and raise it in the same step; a gap lowers it first.
  task automatic send_request(logic [1:0] kind, logic [31:0] now, logic [15:0] chan,
                              logic [9:0] idx);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, idx, chan, now};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, now, chan, idx);
  endtask

  // Drop valid and wait for every outstanding result, plus the block's latency.
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic load_registers(logic [9:0] incr, logic [9:0] leak, logic [9:0] size,
                                logic all, logic [15:0] chan);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_BUCKET_INCREMENT, CFG_LEAK_PER_SLOT, CFG_BUCKET_SIZE,
            CFG_POLICE_ALL, CFG_POLICED_CHANNEL};
    val = '{{6'd0, incr}, {6'd0, leak}, {6'd0, size}, {15'd0, all}, chan};
    drain_requests();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly a slowly rising time base; now and then it steps back, jumps far
  // ahead or lands anywhere (which can wrap).
  task automatic advance_slot();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) cur_slot = cur_slot + $urandom_range(0, 4);
    else if (p < 92) cur_slot = cur_slot - ((cur_slot > 8) ? $urandom_range(1, 8) : cur_slot);
    else if (p < 97) cur_slot = cur_slot + $urandom_range(100, 100000);
    else cur_slot = $urandom;
  endtask

  task automatic run_random(int count, int pause_at);
    int          p;
    logic [15:0] chan;
    logic [9:0]  idx;
    for (int i = 0; i < count; i++) begin
      // Hold off the sender until the pipeline is empty.
      if (i == pause_at) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      p = $urandom_range(0, 99);
      if (p < 80) begin
        advance_slot();
        if (!sb.regs.police_all && $urandom_range(0, 9) < 6) chan = sb.regs.policed_channel;
        else chan = 16'($urandom);
        send_request(KIND_ARRIVAL, cur_slot, chan, 10'($urandom));
      end else if (p < 88) begin
        // mostly levels the bucket can actually reach
        if ($urandom_range(0, 3) == 0) idx = 10'($urandom);
        else idx = 10'($urandom_range(0, sb.regs.bucket_size));
        send_request(KIND_HIST_READ, $urandom, 16'($urandom), idx);
      end else if (p < 97) begin
        advance_slot();
        send_request(KIND_TB_RESET, cur_slot, 16'($urandom), 10'($urandom));
        cur_slot = $urandom_range(0, 3);
      end else begin
        send_request(KIND_HIST_CLEAR, $urandom, 16'($urandom), 10'($urandom));
      end
    end
  endtask

  // Register settings for the random phases: increment, leak, size, police all,
  // policed channel. Zeros and all-ones among them.
  logic [9:0]  set_incr [7] = '{10'd10, 10'd3, 10'd1023, 10'd0, 10'd7, 10'd1, 10'd20};
  logic [9:0]  set_leak [7] = '{10'd5, 10'd1, 10'd1023, 10'd0, 10'd2, 10'd0, 10'd3};
  logic [9:0]  set_size [7] = '{10'd20, 10'd50, 10'd1023, 10'd0, 10'd100, 10'd1023, 10'd60};
  logic        set_all  [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [15:0] set_chan [7] = '{16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'hA5A5,
                                16'h5A5A, 16'h0000};

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, default registers: fill, overflow, leak, time running
    // backwards, huge drain, time base reset, histogram read and clear.
    send_request(KIND_HIST_READ, 32'd0, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd0, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd0, 16'hFFFF, 10'd0);
    send_request(KIND_ARRIVAL, 32'd0, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd1, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd3, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd1, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'hFFFF_FFFF, 16'h8000, 10'h3FF);
    send_request(KIND_TB_RESET, 32'hFFFF_FFFF, 16'd0, 10'd0);
    send_request(KIND_HIST_READ, 32'h5555_5555, 16'hAAAA, 10'd0);
    send_request(KIND_HIST_READ, 32'd0, 16'd0, 10'd10);
    send_request(KIND_HIST_READ, 32'd0, 16'd0, 10'h3FF);
    send_request(KIND_HIST_CLEAR, 32'hAAAA_AAAA, 16'h5555, 10'h2AA);
    send_request(KIND_HIST_READ, 32'd0, 16'd0, 10'd0);
    send_request(KIND_TB_RESET, 32'd100, 16'd0, 10'd0);
    // one channel only, widest bucket, no leak
    load_registers(10'd1023, 10'd0, 10'd1023, 1'b0, 16'hFFFF);
    send_request(KIND_ARRIVAL, 32'd5, 16'd0, 10'd0);
    send_request(KIND_ARRIVAL, 32'd5, 16'hFFFF, 10'd0);
    send_request(KIND_ARRIVAL, 32'd1000, 16'hFFFF, 10'd0);
    // size dropped under the current level: discards until drained
    load_registers(10'd1023, 10'd1, 10'd0, 1'b0, 16'hFFFF);
    send_request(KIND_ARRIVAL, 32'd1010, 16'hFFFF, 10'd0);
    // zero increment into a zero-size bucket, then the largest possible drain
    load_registers(10'd0, 10'd1023, 10'd0, 1'b1, 16'h0000);
    send_request(KIND_ARRIVAL, 32'd1011, 16'h1234, 10'd0);
    send_request(KIND_ARRIVAL, 32'hFFFF_FFFF, 16'h1234, 10'd0);
    send_request(KIND_HIST_READ, 32'd0, 16'd0, 10'd0);

    // Random part: receiver idle then sender idle, then both flat out.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 15;
        rx_idle_pct = 64;
      end else if (ph < 4) begin
        tx_idle_pct = 64;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_registers(set_incr[ph], set_leak[ph], set_size[ph], set_all[ph], set_chan[ph]);
      cur_slot = '0;
      run_random(REQS_PER_PHASE, (ph == 1 || ph == 5) ? REQS_PER_PHASE / 2 : -1);
    end

    drain_requests();
    $display("covered %0d arrivals, %0d time base resets, %0d reads, %0d clears",
             sb.kind_count[KIND_ARRIVAL], sb.kind_count[KIND_TB_RESET],
             sb.kind_count[KIND_HIST_READ], sb.kind_count[KIND_HIST_CLEAR]);
    $display("across %0d register settings; %0d results checked, %0d mismatches",
             settings_used, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_leaky_bucket_cell_policer: done, clean");
    end else begin
      $display("tb_leaky_bucket_cell_policer: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (reset clearing pass, clears
  // walking the whole store, worst stalls on both sides).
  initial begin
    #16_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb_leaky_bucket_cell_policer: done, errors");
    $finish;
  end

endmodule
